// ===== src/xpm_pkg.sv =====
// ----------------------------------------------------------------------------
// xpm_pkg
// Shared widths, codes, config type and popcount helper for the binary
// XNOR/popcount matrix multiply.
// ----------------------------------------------------------------------------
package xpm_pkg;

    localparam int MAX_COLS    = 64;
    localparam int MAX_K_WORDS = 256;
    localparam int WORD_BITS   = 8;
    localparam int STORE_DEPTH = 16384;

    localparam int ADDR_W     = 14;
    localparam int NCOL_W     = 7;
    localparam int KW_W       = 9;
    localparam int ROWS_W     = 16;
    localparam int WC_W       = 8;
    localparam int ACC_W      = 12;
    localparam int PC_W       = 4;
    localparam int DOT_W      = 13;
    localparam int COL_W      = 6;
    localparam int BASE_W     = WC_W + NCOL_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_N_COLS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_K_WORDS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd2;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_WORD = 1'b1;

    typedef struct packed {
        logic [NCOL_W-1:0] ncol;
        logic [KW_W-1:0]   kw;
        logic [ROWS_W-1:0] rows;
    } t_cfg;

    function automatic logic [PC_W-1:0] popcount8(input logic [WORD_BITS-1:0] v);
        logic [PC_W-1:0] c;
        c = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            c = c + PC_W'(v[b]);
        end
        return c;
    endfunction

endpackage

// ===== src/xpm_ram.sv =====
// ----------------------------------------------------------------------------
// xpm_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module xpm_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/xpm_core.sv =====
// ----------------------------------------------------------------------------
// xpm_core
// Sequencer and read-modify-write datapath: walks the columns of one word,
// reads weight and accumulator, writes the accumulator back and emits dots.
// ----------------------------------------------------------------------------
module xpm_core #(
    parameter int MAX_COLS = xpm_pkg::MAX_COLS,
    parameter int CW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  xpm_pkg::t_cfg                 i_cfg,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_action,
    input  logic [xpm_pkg::ADDR_W-1:0]    i_weight_addr,
    input  logic [xpm_pkg::WORD_BITS-1:0] i_data_word,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [xpm_pkg::COL_W-1:0]     o_col_index,
    output logic [xpm_pkg::DOT_W-1:0]     o_dot_value,
    output logic                          o_last_of_row,
    output logic                          o_last_of_matrix,
    output logic                          o_w_we,
    output logic [xpm_pkg::ADDR_W-1:0]    o_w_waddr,
    output logic [xpm_pkg::WORD_BITS-1:0] o_w_wdata,
    output logic                          o_w_re,
    output logic [xpm_pkg::ADDR_W-1:0]    o_w_raddr,
    input  logic [xpm_pkg::WORD_BITS-1:0] i_w_rdata,
    output logic                          o_a_we,
    output logic [CW-1:0]                 o_a_waddr,
    output logic [xpm_pkg::ACC_W-1:0]     o_a_wdata,
    output logic                          o_a_re,
    output logic [CW-1:0]                 o_a_raddr,
    input  logic [xpm_pkg::ACC_W-1:0]     i_a_rdata
);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_FLUSH} t_state;

    t_state                          r_state;
    logic [xpm_pkg::WC_W-1:0]        r_wc;
    logic [xpm_pkg::ROWS_W-1:0]      r_rowc;
    logic [xpm_pkg::WORD_BITS-1:0]   r_data;
    logic [xpm_pkg::BASE_W-1:0]      r_base;
    logic [xpm_pkg::NCOL_W-1:0]      r_ncol;
    logic [xpm_pkg::KW_W-1:0]        r_kw;
    logic                            r_first;
    logic                            r_last_word;
    logic                            r_last_row;
    logic [CW-1:0]                   r_col;
    logic                            r_s1_v;
    logic [CW-1:0]                   r_s1_col;
    logic                            r_s1_last;
    logic [MAX_COLS-1:0]             r_acc_valid;
    logic                            r_o_valid;
    logic [xpm_pkg::COL_W-1:0]       r_o_col;
    logic [xpm_pkg::DOT_W-1:0]       r_o_dot;
    logic                            r_o_lrow;
    logic                            r_o_lmat;

    logic                            in_acc;
    logic                            act_acc;
    logic                            last_word;
    logic                            last_row;
    logic [xpm_pkg::WC_W-1:0]        n_wc;
    logic [xpm_pkg::ROWS_W-1:0]      n_rowc;
    logic                            adv1;
    logic                            issue;
    logic                            col_is_last;
    logic [xpm_pkg::PC_W-1:0]        pc;
    logic [xpm_pkg::ACC_W-1:0]       acc_old;
    logic [xpm_pkg::ACC_W-1:0]       acc_new;
    logic [xpm_pkg::DOT_W-1:0]       dot;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign act_acc    = in_acc && (i_action == xpm_pkg::ACT_WORD);

    assign last_word = ({1'b0, r_wc} + 9'd1) >= i_cfg.kw;
    assign last_row  = ({1'b0, r_rowc} + 17'd1) >= {1'b0, i_cfg.rows};

    always_comb begin
        n_wc   = last_word ? '0 : r_wc + 8'd1;
        n_rowc = r_rowc;
        if (last_word) begin
            n_rowc = last_row ? '0 : r_rowc + 16'd1;
        end
    end

    assign adv1  = r_s1_v && (!r_last_word || !r_o_valid || i_out_ready);
    assign issue = (r_state == S_RUN) && (!r_s1_v || adv1);
    assign col_is_last = (xpm_pkg::NCOL_W'(r_col) == (r_ncol - 7'd1));

    assign pc      = xpm_pkg::popcount8(r_data ^ i_w_rdata);
    assign acc_old = r_acc_valid[r_s1_col] ? i_a_rdata : '0;
    assign acc_new = r_first ? xpm_pkg::ACC_W'(pc) : acc_old + xpm_pkg::ACC_W'(pc);
    assign dot     = {1'b0, r_kw, 3'b000} - {acc_new, 1'b0};

    assign o_w_we    = in_acc && (i_action == xpm_pkg::ACT_LOAD);
    assign o_w_waddr = i_weight_addr;
    assign o_w_wdata = i_data_word;
    assign o_w_re    = issue;
    assign o_w_raddr = xpm_pkg::ADDR_W'(r_base + xpm_pkg::BASE_W'(r_col));

    assign o_a_re    = issue;
    assign o_a_raddr = r_col;
    assign o_a_we    = adv1;
    assign o_a_waddr = r_s1_col;
    assign o_a_wdata = acc_new;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wc        <= '0;
            r_rowc      <= '0;
            r_s1_v      <= 1'b0;
            r_acc_valid <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (act_acc) begin
                        r_data      <= i_data_word;
                        r_base      <= xpm_pkg::BASE_W'({7'd0, r_wc} * {8'd0, i_cfg.ncol});
                        r_ncol      <= i_cfg.ncol;
                        r_kw        <= i_cfg.kw;
                        r_first     <= (r_wc == '0);
                        r_last_word <= last_word;
                        r_last_row  <= last_row;
                        r_col       <= '0;
                        r_wc        <= n_wc;
                        r_rowc      <= n_rowc;
                        r_state     <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (issue) begin
                        r_col <= r_col + CW'(1);
                        if (col_is_last) begin
                            r_state <= S_FLUSH;
                        end
                    end
                end
                S_FLUSH: begin
                    if (adv1) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (issue) begin
                r_s1_v    <= 1'b1;
                r_s1_col  <= r_col;
                r_s1_last <= col_is_last;
            end else if (adv1) begin
                r_s1_v <= 1'b0;
            end

            if (adv1) begin
                r_acc_valid[r_s1_col] <= 1'b1;
            end

            if (adv1 && r_last_word) begin
                r_o_valid <= 1'b1;
                r_o_col   <= xpm_pkg::COL_W'(r_s1_col);
                r_o_dot   <= dot;
                r_o_lrow  <= r_s1_last;
                r_o_lmat  <= r_s1_last && r_last_row;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_col_index      = r_o_col;
    assign o_dot_value      = r_o_dot;
    assign o_last_of_row    = r_o_lrow;
    assign o_last_of_matrix = r_o_lmat;

endmodule

// ===== src/xnor_popcount_matmul.sv =====
// ----------------------------------------------------------------------------
// xnor_popcount_matmul
// Binary matrix multiply by XNOR and popcount over 8-bit packed sign words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one word: a weight load
//   (i_action = 0) written to the weight store at i_weight_addr, or an
//   activation byte (i_action = 1), k_words of them per row.
//   Output channel (o_out_valid / i_out_ready) carries one word per column,
//   in column order, after the last activation byte of a row.
//   Config port: i_cfg_we, i_cfg_index, i_cfg_data; write while idle.
// Sequencing:
//   A load is written straight to the weight store. For an activation byte
//   the column walk reads weight and accumulator RAM one column per cycle
//   unless a stalled result holds it, then a flush state returns to idle.
//   Each result passes the RAM read stage and then the output register.
// Reset: counters and accumulator valid bits clear, registers return to 1;
//   the weight store keeps its contents and is undefined until written.
// Stall: a stalled result holds the column walk; input is not taken until
//   the walk finishes.
// ----------------------------------------------------------------------------
module xnor_popcount_matmul #(
    parameter int MAX_COLS = xpm_pkg::MAX_COLS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [xpm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [xpm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_action,
    input  logic [xpm_pkg::ADDR_W-1:0]     i_weight_addr,
    input  logic [xpm_pkg::WORD_BITS-1:0]  i_data_word,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [xpm_pkg::COL_W-1:0]      o_col_index,
    output logic signed [xpm_pkg::DOT_W-1:0] o_dot_value,
    output logic                           o_last_of_row,
    output logic                           o_last_of_matrix
);

    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    logic [xpm_pkg::NCOL_W-1:0] r_n_cols;
    logic [xpm_pkg::KW_W-1:0]   r_k_words;
    logic [xpm_pkg::ROWS_W-1:0] r_row_count;
    xpm_pkg::t_cfg              cfg;

    logic                          w_we;
    logic [xpm_pkg::ADDR_W-1:0]    w_waddr;
    logic [xpm_pkg::WORD_BITS-1:0] w_wdata;
    logic                          w_re;
    logic [xpm_pkg::ADDR_W-1:0]    w_raddr;
    logic [xpm_pkg::WORD_BITS-1:0] w_rdata;
    logic                          a_we;
    logic [CW-1:0]                 a_waddr;
    logic [xpm_pkg::ACC_W-1:0]     a_wdata;
    logic                          a_re;
    logic [CW-1:0]                 a_raddr;
    logic [xpm_pkg::ACC_W-1:0]     a_rdata;
    logic [xpm_pkg::DOT_W-1:0]     dot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_cols    <= 7'd1;
            r_k_words   <= 9'd1;
            r_row_count <= 16'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                xpm_pkg::REG_N_COLS:    r_n_cols    <= i_cfg_data[xpm_pkg::NCOL_W-1:0];
                xpm_pkg::REG_K_WORDS:   r_k_words   <= i_cfg_data[xpm_pkg::KW_W-1:0];
                xpm_pkg::REG_ROW_COUNT: r_row_count <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // clamp to the supported ranges
    always_comb begin
        cfg.ncol = r_n_cols;
        if (r_n_cols == '0) begin
            cfg.ncol = 7'd1;
        end else if (r_n_cols > xpm_pkg::NCOL_W'(MAX_COLS)) begin
            cfg.ncol = xpm_pkg::NCOL_W'(MAX_COLS);
        end
        cfg.kw = r_k_words;
        if (r_k_words == '0) begin
            cfg.kw = 9'd1;
        end else if (r_k_words > xpm_pkg::KW_W'(xpm_pkg::MAX_K_WORDS)) begin
            cfg.kw = xpm_pkg::KW_W'(xpm_pkg::MAX_K_WORDS);
        end
        cfg.rows = (r_row_count == '0) ? 16'd1 : r_row_count;
    end

    xpm_core #(
        .MAX_COLS (MAX_COLS),
        .CW       (CW)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_action         (i_action),
        .i_weight_addr    (i_weight_addr),
        .i_data_word      (i_data_word),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_col_index      (o_col_index),
        .o_dot_value      (dot),
        .o_last_of_row    (o_last_of_row),
        .o_last_of_matrix (o_last_of_matrix),
        .o_w_we           (w_we),
        .o_w_waddr        (w_waddr),
        .o_w_wdata        (w_wdata),
        .o_w_re           (w_re),
        .o_w_raddr        (w_raddr),
        .i_w_rdata        (w_rdata),
        .o_a_we           (a_we),
        .o_a_waddr        (a_waddr),
        .o_a_wdata        (a_wdata),
        .o_a_re           (a_re),
        .o_a_raddr        (a_raddr),
        .i_a_rdata        (a_rdata)
    );

    xpm_ram #(
        .DEPTH (xpm_pkg::STORE_DEPTH),
        .WIDTH (xpm_pkg::WORD_BITS),
        .AW    (xpm_pkg::ADDR_W)
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    xpm_ram #(
        .DEPTH (MAX_COLS),
        .WIDTH (xpm_pkg::ACC_W),
        .AW    (CW)
    ) u_accum_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (a_wdata),
        .i_re    (a_re),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    assign o_dot_value = $signed(dot);

endmodule

// ===== src/xpm_checker.sv =====
// ----------------------------------------------------------------------------
// xpm_checker
// Port-level checks for xnor_popcount_matmul, attached by bind.
// ----------------------------------------------------------------------------
module xpm_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [xpm_pkg::COL_W-1:0]      o_col_index,
    input logic signed [xpm_pkg::DOT_W-1:0] o_dot_value,
    input logic                           o_last_of_row,
    input logic                           o_last_of_matrix
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_col_index)
            && $stable(o_dot_value) && $stable(o_last_of_row)
            && $stable(o_last_of_matrix))
        else $error("stalled output word changed");

    a_mat_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_of_matrix |-> o_last_of_row)
        else $error("last of matrix without last of row");

    a_dot_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_dot_value[0] == 1'b0))
        else $error("dot value is odd");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind xnor_popcount_matmul xpm_checker u_xpm_checker (.*);

// ===== dv/xnor_popcount_matmul_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xnor_popcount_matmul_tb
// Self-checking bench for the binary XNOR/popcount matrix multiply. A short
// scripted sequence covers field extremes, out-of-range register values and
// register changes in the middle of a row or matrix. Random phases follow:
// each sets the registers, loads every weight byte that the phase will read,
// and streams whole and partial activation rows mixed with stray loads. A
// built-in model of the column accumulators forecasts every column word,
// which is checked in order against the output channel.
// ----------------------------------------------------------------------------
module xnor_popcount_matmul_tb;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE       = 2 * xpm_pkg::MAX_COLS + 8;
    localparam int HOLD_CYCLES  = 2000;
    localparam int RAND_ITEMS   = 100;
    localparam int SCRIPT_LEN   = 26;
    localparam logic NO_CHK     = 1'b0;
    localparam logic CHK        = 1'b1;

    localparam logic [xpm_pkg::CFG_IDX_W-1:0] R_NCOL = xpm_pkg::REG_N_COLS;
    localparam logic [xpm_pkg::CFG_IDX_W-1:0] R_KW   = xpm_pkg::REG_K_WORDS;
    localparam logic [xpm_pkg::CFG_IDX_W-1:0] R_ROWS = xpm_pkg::REG_ROW_COUNT;
    localparam logic A_LOAD = xpm_pkg::ACT_LOAD;
    localparam logic A_WORD = xpm_pkg::ACT_WORD;

    typedef enum logic {ROW_REG, ROW_ITEM} t_row_kind;

    typedef struct packed {
        t_row_kind                        kind;
        logic [xpm_pkg::CFG_IDX_W-1:0]    reg_idx;
        logic [xpm_pkg::CFG_DATA_W-1:0]   reg_val;
        logic                             action;
        logic [xpm_pkg::ADDR_W-1:0]       addr;
        logic [xpm_pkg::WORD_BITS-1:0]    data;
        logic                             typed;
        logic signed [xpm_pkg::DOT_W-1:0] dot;
        logic                             mat_end;
    } t_script_row;

    typedef struct packed {
        logic [xpm_pkg::COL_W-1:0]        col;
        logic signed [xpm_pkg::DOT_W-1:0] dot;
        logic                             row_end;
        logic                             mat_end;
    } t_col_result;

    // typed rows all run with one column, so they expect column 0, last of row
    localparam t_script_row SCRIPT [SCRIPT_LEN] = '{
        '{ROW_ITEM, R_NCOL, 16'd0, A_LOAD, 14'd0,    8'hFF, NO_CHK,  13'sd0, 1'b0},
        '{ROW_ITEM, R_NCOL, 16'd0, A_WORD, 14'd0,    8'hFF, CHK,     13'sd8, 1'b1},
        '{ROW_ITEM, R_NCOL, 16'd0, A_WORD, 14'h3FFF, 8'h00, CHK,    -13'sd8, 1'b1},
        '{ROW_ITEM, R_NCOL, 16'd0, A_LOAD, 14'h3FFF, 8'h00, NO_CHK,  13'sd0, 1'b0},
        '{ROW_ITEM, R_NCOL, 16'd0, A_LOAD, 14'd0,    8'h0F, NO_CHK,  13'sd0, 1'b0},
        '{ROW_ITEM, R_NCOL, 16'd0, A_WORD, 14'd0,    8'hF0, CHK,    -13'sd8, 1'b1},
        '{ROW_ITEM, R_NCOL, 16'd0, A_WORD, 14'd0,    8'h0E, CHK,     13'sd6, 1'b1},
        '{ROW_REG,  R_ROWS, 16'd0, A_LOAD, 14'd0,    8'h00, NO_CHK,  13'sd0, 1'b0},
        '{ROW_ITEM, R_NCOL, 16'd0, A_WORD, 14'd0,    8'h0F, CHK,     13'sd8, 1'b1},
        '{ROW_REG,  R_NCOL, 16'd0, A_LOAD, 14'd0,    8'h00, NO_CHK,  13'sd0, 1'b0},
        '{ROW_REG,  R_KW,   16'd0, A_LOAD, 14'd0,    8'h00, NO_CHK,  13'sd0, 1'b0},
        '{ROW_ITEM, R_NCOL, 16'd0, A_WORD, 14'd0,    8'h8F, CHK,     13'sd6, 1'b1},
        '{ROW_REG,  R_ROWS, 16'd3, A_LOAD, 14'd0,    8'h00, NO_CHK,  13'sd0, 1'b0},
        '{ROW_ITEM, R_NCOL, 16'd0, A_WORD, 14'd0,    8'h0F, CHK,     13'sd8, 1'b0},
        '{ROW_ITEM, R_NCOL, 16'd0, A_WORD, 14'd0,    8'h0F, CHK,     13'sd8, 1'b0},
        '{ROW_ITEM, R_NCOL, 16'd0, A_WORD, 14'd0,    8'h0F, CHK,     13'sd8, 1'b1},
        '{ROW_REG,  R_KW,   16'd3, A_LOAD, 14'd0,    8'h00, NO_CHK,  13'sd0, 1'b0},
        '{ROW_ITEM, R_NCOL, 16'd0, A_LOAD, 14'd1,    8'h55, NO_CHK,  13'sd0, 1'b0},
        '{ROW_ITEM, R_NCOL, 16'd0, A_LOAD, 14'd2,    8'hAA, NO_CHK,  13'sd0, 1'b0},
        '{ROW_ITEM, R_NCOL, 16'd0, A_WORD, 14'd0,    8'h0F, NO_CHK,  13'sd0, 1'b0},
        '{ROW_ITEM, R_NCOL, 16'd0, A_WORD, 14'd0,    8'h55, NO_CHK,  13'sd0, 1'b0},
        '{ROW_REG,  R_KW,   16'd2, A_LOAD, 14'd0,    8'h00, NO_CHK,  13'sd0, 1'b0},
        '{ROW_ITEM, R_NCOL, 16'd0, A_WORD, 14'd0,    8'h00, CHK,     13'sd8, 1'b0},
        '{ROW_REG,  R_ROWS, 16'd1, A_LOAD, 14'd0,    8'h00, NO_CHK,  13'sd0, 1'b0},
        '{ROW_REG,  R_KW,   16'd1, A_LOAD, 14'd0,    8'h00, NO_CHK,  13'sd0, 1'b0},
        '{ROW_ITEM, R_NCOL, 16'd0, A_WORD, 14'd0,    8'hF0, CHK,    -13'sd8, 1'b1}
    };

    logic                             clk         = 1'b0;
    logic                             rst_n       = 1'b0;
    logic                             cfg_we      = 1'b0;
    logic [xpm_pkg::CFG_IDX_W-1:0]    cfg_index   = '0;
    logic [xpm_pkg::CFG_DATA_W-1:0]   cfg_data    = '0;
    logic                             in_valid    = 1'b0;
    logic                             action      = A_LOAD;
    logic [xpm_pkg::ADDR_W-1:0]       weight_addr = '0;
    logic [xpm_pkg::WORD_BITS-1:0]    data_word   = '0;
    logic                             out_ready   = 1'b0;
    logic                             o_in_ready;
    logic                             o_out_valid;
    logic [xpm_pkg::COL_W-1:0]        o_col_index;
    logic signed [xpm_pkg::DOT_W-1:0] o_dot_value;
    logic                             o_last_of_row;
    logic                             o_last_of_matrix;

    logic [xpm_pkg::WORD_BITS-1:0]    weights [xpm_pkg::STORE_DEPTH];
    logic [xpm_pkg::ACC_W-1:0]        mism [xpm_pkg::MAX_COLS] = '{default: '0};
    int unsigned                      word_pos = 0;
    int unsigned                      row_pos  = 0;
    xpm_pkg::t_cfg                    reg_shadow = '{ncol: 7'd1, kw: 9'd1, rows: 16'd1};
    t_col_result                      dots_due [$];
    t_col_result                      want;

    int                     errors     = 0;
    int                     rand_items = 0;
    int                     cycles     = 0;
    bit                     quiet      = 1'b0;
    bit                     hold_req   = 1'b0;
    bit                     hold_done  = 1'b0;
    int                     hold_left  = 0;
    int                     gap_left   = 0;

    xnor_popcount_matmul uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_ready       (o_in_ready),
        .i_action         (action),
        .i_weight_addr    (weight_addr),
        .i_data_word      (data_word),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .o_col_index      (o_col_index),
        .o_dot_value      (o_dot_value),
        .o_last_of_row    (o_last_of_row),
        .o_last_of_matrix (o_last_of_matrix)
    );

    always #5 clk = ~clk;

    function automatic int unsigned active_cols();
        if (reg_shadow.ncol == 0) return 1;
        return (reg_shadow.ncol > xpm_pkg::MAX_COLS) ? xpm_pkg::MAX_COLS : reg_shadow.ncol;
    endfunction

    function automatic int unsigned active_words();
        if (reg_shadow.kw == 0) return 1;
        return (reg_shadow.kw > xpm_pkg::MAX_K_WORDS) ? xpm_pkg::MAX_K_WORDS : reg_shadow.kw;
    endfunction

    task automatic xnor_accumulate(input logic act, input logic [xpm_pkg::ADDR_W-1:0] addr,
                                   input logic [xpm_pkg::WORD_BITS-1:0] data);
        int unsigned ncol, kw, rows, loc;
        int          dot;
        logic        end_row;
        t_col_result r;
        ncol = active_cols();
        kw   = active_words();
        rows = (reg_shadow.rows == 0) ? 1 : reg_shadow.rows;
        if (act == A_LOAD) begin
            weights[addr] = data;
        end else begin
            for (int c = 0; c < ncol; c++) begin
                loc = (word_pos * ncol + c) % xpm_pkg::STORE_DEPTH;
                if (word_pos == 0)
                    mism[c] = xpm_pkg::ACC_W'($countones(data ^ weights[loc]));
                else
                    mism[c] = mism[c] + xpm_pkg::ACC_W'($countones(data ^ weights[loc]));
            end
            if (word_pos + 1 < kw) begin
                word_pos = (word_pos + 1) & 8'hFF;
            end else begin
                word_pos = 0;
                end_row  = (row_pos + 1 >= rows);
                for (int c = 0; c < ncol; c++) begin
                    dot       = int'(xpm_pkg::WORD_BITS * kw) - 2 * int'(mism[c]);
                    r.col     = xpm_pkg::COL_W'(c);
                    r.dot     = xpm_pkg::DOT_W'(dot);
                    r.row_end = (c + 1 == ncol);
                    r.mat_end = r.row_end && end_row;
                    dots_due.push_back(r);
                end
                row_pos = end_row ? 0 : ((row_pos + 1) & 16'hFFFF);
            end
        end
    endtask

    task automatic offer(input logic act, input logic [xpm_pkg::ADDR_W-1:0] addr,
                         input logic [xpm_pkg::WORD_BITS-1:0] data);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 11);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        weight_addr <= addr;
        data_word   <= data;
        do @(posedge clk); while (!o_in_ready);
        xnor_accumulate(act, addr, data);
    endtask

    task automatic write_reg(input logic [xpm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [xpm_pkg::CFG_DATA_W-1:0] val);
        in_valid <= 1'b0;
        while (dots_due.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            R_NCOL:  reg_shadow.ncol = val[xpm_pkg::NCOL_W-1:0];
            R_KW:    reg_shadow.kw   = val[xpm_pkg::KW_W-1:0];
            R_ROWS:  reg_shadow.rows = val[xpm_pkg::ROWS_W-1:0];
            default: ;
        endcase
    endtask

    function automatic logic [xpm_pkg::WORD_BITS-1:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return xpm_pkg::WORD_BITS'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic flag(input string what, input int wanted, input int got);
        $display("%0t %s mismatch: expected %0d, got %0d", $time, what, wanted, got);
        errors++;
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (gap_left != 0) begin
            out_ready <= 1'b0;
            gap_left  <= gap_left - 1;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            out_ready <= 1'b0;
            gap_left  <= $urandom_range(0, 10);
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n && o_out_valid && out_ready) begin
            if (dots_due.size() == 0) begin
                $display("%0t unexpected column word: col %0d dot %0d", $time,
                         o_col_index, o_dot_value);
                errors++;
            end else begin
                want = dots_due.pop_front();
                if (o_col_index !== want.col) flag("col_index", want.col, o_col_index);
                if (o_dot_value !== want.dot) flag("dot_value", want.dot, o_dot_value);
                if (o_last_of_row !== want.row_end)
                    flag("last_of_row", want.row_end, o_last_of_row);
                if (o_last_of_matrix !== want.mat_end)
                    flag("last_of_matrix", want.mat_end, o_last_of_matrix);
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        logic [xpm_pkg::NCOL_W-1:0] nc;
        logic [xpm_pkg::KW_W-1:0]   kw;
        logic [xpm_pkg::ROWS_W-1:0] rows;
        int unsigned                span, n_words, eff_k;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < SCRIPT_LEN; i++) begin
            if (SCRIPT[i].kind == ROW_REG) begin
                write_reg(SCRIPT[i].reg_idx, SCRIPT[i].reg_val);
            end else begin
                offer(SCRIPT[i].action, SCRIPT[i].addr, SCRIPT[i].data);
                if (SCRIPT[i].typed)
                    dots_due[dots_due.size() - 1] = '{xpm_pkg::COL_W'(0), SCRIPT[i].dot,
                                                      1'b1, SCRIPT[i].mat_end};
            end
        end

        // phase 0 spans every column with one-word rows
        for (int ph = 0; rand_items < RAND_ITEMS; ph++) begin
            if (ph == 0) begin
                nc   = 7'd127;
                kw   = 9'd1;
                rows = xpm_pkg::ROWS_W'($urandom_range(1, 3));
            end else begin
                case ($urandom_range(0, 5))
                    0: nc = '0;
                    default: nc = xpm_pkg::NCOL_W'($urandom_range(1, 6));
                endcase
                case ($urandom_range(0, 5))
                    0: kw = '0;
                    1: kw = xpm_pkg::KW_W'($urandom_range(5, 12));
                    default: kw = xpm_pkg::KW_W'($urandom_range(1, 4));
                endcase
                if (kw > 9'd4 && nc > 7'd2)
                    nc = 7'd2;
                case ($urandom_range(0, 7))
                    0: rows = '0;
                    1: rows = 16'hFFFF;
                    default: rows = xpm_pkg::ROWS_W'($urandom_range(1, 3));
                endcase
            end
            write_reg(R_NCOL, xpm_pkg::CFG_DATA_W'(nc));
            write_reg(R_KW, xpm_pkg::CFG_DATA_W'(kw));
            write_reg(R_ROWS, xpm_pkg::CFG_DATA_W'(rows));
            eff_k = active_words();

            // cover a row left open by an earlier phase as well
            span = ((word_pos + 1 > eff_k) ? word_pos + 1 : eff_k) * active_cols();
            for (int a = 0; a < span && a < xpm_pkg::STORE_DEPTH; a++) begin
                offer(A_LOAD, xpm_pkg::ADDR_W'(a), pick_byte());
                rand_items++;
            end

            n_words = eff_k * $urandom_range(1, 3) +
                      (($urandom_range(0, 3) == 0) ? $urandom_range(0, eff_k - 1) : 0);
            if (ph == 1) hold_req = 1'b1;
            for (int w = 0; w < n_words; w++) begin
                if ($urandom_range(0, 9) == 0) begin
                    offer(A_LOAD, xpm_pkg::ADDR_W'($urandom), pick_byte());
                    rand_items++;
                end
                offer(A_WORD, xpm_pkg::ADDR_W'($urandom), pick_byte());
                rand_items++;
            end

            // change the row or matrix length while counters are mid-way
            if ($urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 1) == 1)
                    write_reg(R_KW, xpm_pkg::CFG_DATA_W'($urandom_range(0, eff_k)));
                else
                    write_reg(R_ROWS, xpm_pkg::CFG_DATA_W'($urandom_range(0, 3)));
                n_words = $urandom_range(1, 4);
                for (int w = 0; w < n_words; w++) begin
                    offer(A_WORD, xpm_pkg::ADDR_W'($urandom), pick_byte());
                    rand_items++;
                end
            end
            quiet = (rand_items >= RAND_ITEMS - RAND_ITEMS / 5);
        end

        in_valid <= 1'b0;
        while (dots_due.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
src/xpm_pkg.sv
src/xpm_ram.sv
src/xpm_core.sv
src/xnor_popcount_matmul.sv
src/xpm_checker.sv
dv/xnor_popcount_matmul_tb.sv
